// ===== src/rectangle_raster_framebuffer_assert.svh =====
// assertion macros used by the rectangle raster framebuffer rtl
`ifndef RECTANGLE_RASTER_FRAMEBUFFER_ASSERT_SVH
`define RECTANGLE_RASTER_FRAMEBUFFER_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define RRF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rrf assertion failed");
// condition must never be seen outside reset
`define RRF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `RRF_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define RRF_ASSERT(lbl, clk, rst_n, prop)
`define RRF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/rrf_pkg.sv =====
package rrf_pkg;

  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 256;
  localparam int FRAC_BITS = 8;

  localparam int COORD_W = 20;
  localparam int CHAR_W  = 8;
  localparam int RD_W    = 8;
  localparam int CFG_W   = 9;

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNTC_W = $clog2(MAX_COLS + 1);
  localparam int CNTR_W = $clog2(MAX_ROWS + 1);
  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // pixel positions scaled to fixed point, plus sign
  localparam int PIX_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + FRAC_BITS + 1;
  localparam int CALC_W = ((PIX_W > COORD_W + 1) ? PIX_W : COORD_W + 1) + 1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_CANVAS_WIDTH  = 2'd0,
    CFG_CANVAS_HEIGHT = 2'd1,
    CFG_BACKGROUND    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SWEEP,
    FSM_FINISH
  } fsm_state_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_span_x;
    logic signed [COORD_W-1:0] rect_span_y;
    logic                      filled;
    logic [CHAR_W-1:0]         paint_char;
    logic [RD_W-1:0]           read_col;
    logic [RD_W-1:0]           read_row;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CHAR_W-1:0] pixel_value;
  } result_t;

  typedef struct packed {
    logic load;
    logic sweep;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_sweep;
    logic sweep_last;
  } dp_status_t;

endpackage

// ===== src/rrf_req_if.sv =====
interface rrf_req_if;
  import rrf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic signed [COORD_W-1:0] rect_left;
  logic signed [COORD_W-1:0] rect_top;
  logic signed [COORD_W-1:0] rect_span_x;
  logic signed [COORD_W-1:0] rect_span_y;
  logic                      filled;
  logic [CHAR_W-1:0]         paint_char;
  logic [RD_W-1:0]           read_col;
  logic [RD_W-1:0]           read_row;

  modport source (
    output valid, cmd, rect_left, rect_top, rect_span_x, rect_span_y,
           filled, paint_char, read_col, read_row,
    input  ready
  );

  modport sink (
    input  valid, cmd, rect_left, rect_top, rect_span_x, rect_span_y,
           filled, paint_char, read_col, read_row,
    output ready
  );
endinterface

// ===== src/rrf_rsp_if.sv =====
interface rrf_rsp_if;
  import rrf_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [CHAR_W-1:0] pixel_value;

  modport source (
    output valid, status, pixel_value,
    input  ready
  );

  modport sink (
    input  valid, status, pixel_value,
    output ready
  );
endinterface

// ===== src/rectangle_raster_framebuffer.sv =====
// character framebuffer drawn with axis-aligned rectangles
// req_i takes one command per transaction: clear, draw rectangle or read pixel;
// rsp_o returns exactly one transaction per command with status and pixel value.
// configuration (canvas size, background char) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while no command is in flight.
// a clear or an accepted draw sweeps the canvas in use one pixel per
// cycle before the result is loaded into the output register once that is free;
// a read, a rejected draw or an unused command skips the sweep and is loaded so.
// the frame store takes one write and one read per cycle; the sweep writes
// through the write port over up to a full 256x256 canvas.
// one command is processed at a time; req_i.ready rises in the cycle the result
// enters the output register, so no new command is taken until the result of the
// previous one has been registered.
// when the receiver stalls, the result waits in the output register while the
// next command is accepted and processed; that command then waits to deliver.
// reset clears the control state and sets the canvas to 1x1 with a space as
// background; the frame store holds nothing valid until the first clear.
module rectangle_raster_framebuffer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rrf_req_if.sink                     req_i,
  rrf_rsp_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [rrf_pkg::CFG_W-1:0]   cfg_data_i
);
  import rrf_pkg::*;

  logic [CFG_W-1:0]  canvas_width_q, canvas_height_q;
  logic [CHAR_W-1:0] background_char_q;
  item_t             item;
  result_t           result;
  dp_cmd_t           dp_cmd;
  dp_status_t        dp_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q    <= CFG_W'(1);
      canvas_height_q   <= CFG_W'(1);
      background_char_q <= CHAR_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CANVAS_WIDTH:  canvas_width_q    <= cfg_data_i;
        CFG_CANVAS_HEIGHT: canvas_height_q   <= cfg_data_i;
        CFG_BACKGROUND:    background_char_q <= cfg_data_i[CHAR_W-1:0];
        default: begin
          canvas_width_q <= canvas_width_q;
        end
      endcase
    end
  end

  assign item.cmd         = req_i.cmd;
  assign item.rect_left   = req_i.rect_left;
  assign item.rect_top    = req_i.rect_top;
  assign item.rect_span_x = req_i.rect_span_x;
  assign item.rect_span_y = req_i.rect_span_y;
  assign item.filled      = req_i.filled;
  assign item.paint_char  = req_i.paint_char;
  assign item.read_col    = req_i.read_col;
  assign item.read_row    = req_i.read_row;

  rrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  rrf_dp u_dp (
    .clk_i             (clk_i),
    .item_i            (item),
    .canvas_width_i    (canvas_width_q),
    .canvas_height_i   (canvas_height_q),
    .background_char_i (background_char_q),
    .dp_cmd_i          (dp_cmd),
    .dp_status_o       (dp_status),
    .result_o          (result)
  );

  assign rsp_o.status      = result.status;
  assign rsp_o.pixel_value = result.pixel_value;
endmodule

// ===== src/rrf_ram.sv =====
module rrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/rrf_ctrl.sv =====
`include "rectangle_raster_framebuffer_assert.svh"

module rrf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rrf_pkg::dp_status_t dp_status_i,
  output rrf_pkg::dp_cmd_t    dp_cmd_o
);
  import rrf_pkg::*;

  fsm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign accept    = in_valid_i && in_ready_o;
  // the output register can take a new result when empty or being drained
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = dp_status_i.needs_sweep ? FSM_SWEEP : FSM_FINISH;
        end
      end
      FSM_SWEEP: begin
        if (dp_status_i.sweep_last) begin
          state_d = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        if (slot_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    dp_cmd_o.load     = 1'b0;
    dp_cmd_o.sweep    = 1'b0;
    dp_cmd_o.out_load = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o    = 1'b1;
        dp_cmd_o.load = in_valid_i;
      end
      FSM_SWEEP: begin
        dp_cmd_o.sweep = 1'b1;
      end
      FSM_FINISH: begin
        dp_cmd_o.out_load = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (dp_cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `RRF_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, accept |=> !in_ready_o)
  `RRF_ASSERT(a_load_needs_slot, clk_i, rst_ni, dp_cmd_o.out_load |-> slot_free)
  `RRF_ASSERT(a_load_sets_valid, clk_i, rst_ni, dp_cmd_o.out_load |=> out_valid_o)
  `RRF_ASSERT(a_sweep_runs_to_end, clk_i, rst_ni,
    (dp_cmd_o.sweep && !dp_status_i.sweep_last) |=> dp_cmd_o.sweep)
  `RRF_ASSERT_NEVER(a_sweep_while_ready, clk_i, rst_ni, dp_cmd_o.sweep && in_ready_o)
endmodule

// ===== src/rrf_dp.sv =====
module rrf_dp (
  input  logic                        clk_i,
  input  rrf_pkg::item_t              item_i,
  input  logic [rrf_pkg::CFG_W-1:0]   canvas_width_i,
  input  logic [rrf_pkg::CFG_W-1:0]   canvas_height_i,
  input  logic [rrf_pkg::CHAR_W-1:0]  background_char_i,
  input  rrf_pkg::dp_cmd_t            dp_cmd_i,
  output rrf_pkg::dp_status_t         dp_status_o,
  output rrf_pkg::result_t            result_o
);
  import rrf_pkg::*;

  localparam logic signed [CALC_W-1:0] ONE_FX = CALC_W'(1 << FRAC_BITS);

  logic [CNTC_W-1:0] cols_used;
  logic [CNTR_W-1:0] rows_used;
  logic              span_ok;
  logic              read_in;
  logic              needs_sweep;

  logic              clear_q;
  logic              fill_q;
  logic [CHAR_W-1:0] ch_q;
  logic signed [CALC_W-1:0] left_q, top_q, right_q, bottom_q;
  logic [CNTC_W-1:0] cols_q;
  logic [CNTR_W-1:0] rows_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [1:0]        status_q;
  logic              rd_sel_q;
  result_t           result_q;

  logic              col_last, row_last;
  logic signed [CALC_W-1:0] px, py, dl, dr, dt, db;
  logic              in_x, in_y, border, paint;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CHAR_W-1:0] wdata, rdata;

  // out-of-range canvas sizes are clamped
  always_comb begin
    if (canvas_width_i == '0) begin
      cols_used = CNTC_W'(1);
    end else if (int'(canvas_width_i) > MAX_COLS) begin
      cols_used = CNTC_W'(MAX_COLS);
    end else begin
      cols_used = CNTC_W'(canvas_width_i);
    end
    if (canvas_height_i == '0) begin
      rows_used = CNTR_W'(1);
    end else if (int'(canvas_height_i) > MAX_ROWS) begin
      rows_used = CNTR_W'(MAX_ROWS);
    end else begin
      rows_used = CNTR_W'(canvas_height_i);
    end
  end

  assign span_ok = (item_i.rect_span_x > 0) && (item_i.rect_span_y > 0);
  assign read_in = (int'(item_i.read_col) < int'(cols_used)) &&
                   (int'(item_i.read_row) < int'(rows_used));

  always_comb begin
    case (item_i.cmd)
      CMD_CLEAR: needs_sweep = 1'b1;
      CMD_DRAW:  needs_sweep = span_ok;
      default:   needs_sweep = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      clear_q  <= (item_i.cmd == CMD_CLEAR);
      fill_q   <= item_i.filled;
      ch_q     <= item_i.paint_char;
      left_q   <= CALC_W'(item_i.rect_left);
      top_q    <= CALC_W'(item_i.rect_top);
      right_q  <= CALC_W'(item_i.rect_left) + CALC_W'(item_i.rect_span_x);
      bottom_q <= CALC_W'(item_i.rect_top) + CALC_W'(item_i.rect_span_y);
      cols_q   <= cols_used;
      rows_q   <= rows_used;
      col_q    <= '0;
      row_q    <= '0;
      rd_sel_q <= (item_i.cmd == CMD_READ) && read_in;
      case (item_i.cmd)
        CMD_DRAW: status_q <= span_ok ? ST_OK : ST_REJECT;
        CMD_READ: status_q <= read_in ? ST_OK : ST_OUTSIDE;
        default:  status_q <= ST_OK;
      endcase
    end else if (dp_cmd_i.sweep) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
    if (dp_cmd_i.out_load) begin
      result_q.status      <= status_q;
      result_q.pixel_value <= rd_sel_q ? rdata : '0;
    end
  end

  assign col_last = (CNTC_W'(col_q) == cols_q - CNTC_W'(1));
  assign row_last = (CNTR_W'(row_q) == rows_q - CNTR_W'(1));
  assign dp_status_o = {needs_sweep, col_last && row_last};

  // containment and border test of the current pixel
  assign px = signed'(CALC_W'(col_q) << FRAC_BITS);
  assign py = signed'(CALC_W'(row_q) << FRAC_BITS);
  assign dl = px - left_q;
  assign dr = right_q - px;
  assign dt = py - top_q;
  assign db = bottom_q - py;
  assign in_x   = !dl[CALC_W-1] && !dr[CALC_W-1];
  assign in_y   = !dt[CALC_W-1] && !db[CALC_W-1];
  assign border = (dl < ONE_FX) || (dr < ONE_FX) || (dt < ONE_FX) || (db < ONE_FX);
  assign paint  = in_x && in_y && (border || fill_q);

  assign we    = dp_cmd_i.sweep && (clear_q || paint);
  assign wdata = clear_q ? background_char_i : ch_q;
  assign waddr = ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);
  assign re    = dp_cmd_i.load && (item_i.cmd == CMD_READ) && read_in;
  assign raddr = ADDR_W'(item_i.read_row) * ADDR_W'(MAX_COLS) + ADDR_W'(item_i.read_col);

  rrf_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign result_o = result_q;
endmodule
